/* design/gsa_pkg.sv */
// shared types, register indexes and reset values for the grid slot allocator
`default_nettype none

package gsa_pkg;

    localparam int MAX_COLS_DEF = 16;
    localparam int MAX_ROWS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIMIT = 3'd6;

    // reset values
    localparam logic [4:0]         RST_GRID_COLS = 5'd16;
    localparam logic [4:0]         RST_GRID_ROWS = 5'd16;
    localparam logic signed [15:0] RST_ORIGIN_X  = 16'sd0;
    localparam logic signed [15:0] RST_ORIGIN_Y  = 16'sd1024;
    localparam logic [11:0]        RST_STEP_X    = 12'd80;
    localparam logic [11:0]        RST_STEP_Y    = 12'd80;
    localparam logic signed [15:0] RST_TOP_LIMIT = 16'sd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HINT,
        ST_SCAN,
        ST_GRANT,
        ST_REL
    } state_t;

endpackage

`default_nettype wire

/* design/grid_slot_allocator_core.sv */
// grid slot allocator: occupancy bitmap in a row memory, hint check, row scan, grant, release
// sequence: a release reads the row and writes it back in ST_REL; a hint reads the row, checks
//   the cell in ST_HINT and grants in ST_GRANT, else ST_SCAN reads rows until a free cell or the last row
// throughput: one request at a time; the scan is paced by the single read port of the
//   occupancy memory (one row per cycle)
// reset: all cells free (per-row valid bits cleared at once), full flag cleared,
//   registers to defaults; the receiver cannot stall, each result shows for one cycle
`default_nettype none

module grid_slot_allocator_core #(
    parameter int MAX_COLS = gsa_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = gsa_pkg::MAX_ROWS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request port
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            mode,
    input  wire logic signed [7:0]               cell_col,
    input  wire logic signed [7:0]               cell_row,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [gsa_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [gsa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // result port
    output logic                                 done,
    output logic                                 ok,
    output logic signed [15:0]                   pos_x,
    output logic signed [15:0]                   pos_y,
    output logic [3:0]                           got_col,
    output logic [3:0]                           got_row,
    output logic                                 full_res
);

    // index widths of the storage
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    // product widths: column times step, and row+1 times step
    localparam int MXW = CW + 12;
    localparam int MYW = RW + 13;
    localparam int MW  = (MXW > MYW) ? MXW : MYW;
    // position width at full precision, with room for sign and the 16-bit origin
    localparam int PW  = ((MW > 16) ? MW : 16) + 2;

    localparam logic [6:0] MAXC7 = 7'(MAX_COLS);
    localparam logic [6:0] MAXR7 = 7'(MAX_ROWS);

    // configuration registers
    logic [4:0]         grid_cols_reg;
    logic [4:0]         grid_rows_reg;
    logic signed [15:0] origin_x_reg;
    logic signed [15:0] origin_y_reg;
    logic [11:0]        step_x_reg;
    logic [11:0]        step_y_reg;
    logic signed [15:0] top_limit_reg;

    // control
    gsa_pkg::state_t state_reg, state_next;
    logic            full_reg, full_next;
    logic            done_reg, done_next;

    // request context
    logic signed [7:0] col_reg, col_next;
    logic signed [7:0] row_reg, row_next;
    logic              hint_ok_reg, hint_ok_next;
    logic [RW-1:0]     chk_r_reg, chk_r_next;
    logic [CW-1:0]     sel_c_reg, sel_c_next;
    logic [RW-1:0]     sel_r_reg, sel_r_next;
    logic [MAX_COLS-1:0] word_reg, word_next;

    // result payload
    logic              ok_reg, ok_next;
    logic signed [15:0] pos_x_reg, pos_x_next;
    logic signed [15:0] pos_y_reg, pos_y_next;
    logic [3:0]        got_col_reg, got_col_next;
    logic [3:0]        got_row_reg, got_row_next;

    // occupancy memory, one word per row, with per-row valid bits
    logic [MAX_COLS-1:0] occ_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_en;
    logic [RW-1:0]       rd_addr;
    logic                wr_en;
    logic [RW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    // derived values
    logic [6:0]          cols_eff;
    logic [6:0]          rows_eff;
    logic [MAX_COLS-1:0] row_word;
    logic                found;
    logic [CW-1:0]       found_c;
    logic [6:0]          chk_r_p1;
    logic [MXW-1:0]      mul_x;
    logic [MYW-1:0]      mul_y;
    logic [RW:0]         row_p1;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [15:0]  px_sat;
    logic signed [15:0]  py_sat;
    logic                in_grid;
    logic                in_store;

    function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
        logic signed [15:0] r;
        if (v > PW'(32767))
            r = 16'sh7fff;
        else if (v < -PW'(32768))
            r = -16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    assign busy     = (state_reg != gsa_pkg::ST_IDLE);
    assign done     = done_reg;
    assign ok       = ok_reg;
    assign pos_x    = pos_x_reg;
    assign pos_y    = pos_y_reg;
    assign got_col  = got_col_reg;
    assign got_row  = got_row_reg;
    assign full_res = full_reg;

    // grid in use is clipped to the storage
    assign cols_eff = ({2'b00, grid_cols_reg} < MAXC7) ? {2'b00, grid_cols_reg} : MAXC7;
    assign rows_eff = ({2'b00, grid_rows_reg} < MAXR7) ? {2'b00, grid_rows_reg} : MAXR7;

    // a row never written since reset reads as all free
    assign row_word = rd_valid_reg ? rd_data_reg : '0;

    // hint / release cell checks on the incoming request
    assign in_store = (cell_col[7] == 1'b0) && ($unsigned(cell_col) < {1'b0, MAXC7})
                   && (cell_row[7] == 1'b0) && ($unsigned(cell_row) < {1'b0, MAXR7});
    assign in_grid  = (cell_col[7] == 1'b0) && ($unsigned(cell_col) < {1'b0, cols_eff})
                   && (cell_row[7] == 1'b0) && ($unsigned(cell_row) < {1'b0, rows_eff});

    // first free column of the row on the read port, within the configured columns
    always_comb
    begin
        found   = 1'b0;
        found_c = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--)
        begin
            if (!row_word[c] && (7'(c) < cols_eff))
            begin
                found   = 1'b1;
                found_c = CW'(c);
            end
        end
    end

    assign chk_r_p1 = 7'(chk_r_reg) + 7'd1;

    // position of the selected cell, full precision
    assign row_p1 = (RW + 1)'(sel_r_reg) + (RW + 1)'(1);
    assign mul_x  = MXW'(sel_c_reg) * MXW'(step_x_reg);
    assign mul_y  = MYW'(row_p1) * MYW'(step_y_reg);
    assign px     = PW'(origin_x_reg) + PW'(signed'({1'b0, mul_x}));
    assign py     = PW'(origin_y_reg) - PW'(signed'({1'b0, mul_y}));
    assign px_sat = sat16(px);
    assign py_sat = sat16(py);

    // next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        full_next    = full_reg;
        done_next    = 1'b0;
        col_next     = col_reg;
        row_next     = row_reg;
        hint_ok_next = hint_ok_reg;
        chk_r_next   = chk_r_reg;
        sel_c_next   = sel_c_reg;
        sel_r_next   = sel_r_reg;
        word_next    = word_reg;
        ok_next      = ok_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        got_col_next = got_col_reg;
        got_row_next = got_row_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = sel_r_reg;
        wr_data      = word_reg;

        case (state_reg)
            gsa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // read the hinted / released row right away
                    col_next     = cell_col;
                    row_next     = cell_row;
                    hint_ok_next = mode ? in_store : in_grid;
                    rd_en        = 1'b1;
                    rd_addr      = cell_row[RW-1:0];
                    state_next   = mode ? gsa_pkg::ST_REL : gsa_pkg::ST_HINT;
                end
            end

            gsa_pkg::ST_HINT:
            begin
                if (hint_ok_reg && !row_word[col_reg[CW-1:0]])
                begin
                    sel_c_next = col_reg[CW-1:0];
                    sel_r_next = row_reg[RW-1:0];
                    word_next  = row_word;
                    state_next = gsa_pkg::ST_GRANT;
                end
                else if (rows_eff == 7'd0)
                begin
                    // empty grid: nothing to scan
                    full_next    = 1'b1;
                    done_next    = 1'b1;
                    ok_next      = 1'b0;
                    pos_x_next   = '0;
                    pos_y_next   = '0;
                    got_col_next = '0;
                    got_row_next = '0;
                    state_next   = gsa_pkg::ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    chk_r_next = '0;
                    state_next = gsa_pkg::ST_SCAN;
                end
            end

            gsa_pkg::ST_SCAN:
            begin
                // row chk_r is on the read port; the next row is fetched meanwhile
                if (found)
                begin
                    sel_c_next = found_c;
                    sel_r_next = chk_r_reg;
                    word_next  = row_word;
                    state_next = gsa_pkg::ST_GRANT;
                end
                else if (chk_r_p1 >= rows_eff)
                begin
                    full_next    = 1'b1;
                    done_next    = 1'b1;
                    ok_next      = 1'b0;
                    pos_x_next   = '0;
                    pos_y_next   = '0;
                    got_col_next = '0;
                    got_row_next = '0;
                    state_next   = gsa_pkg::ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = chk_r_p1[RW-1:0];
                    chk_r_next = chk_r_p1[RW-1:0];
                end
            end

            gsa_pkg::ST_GRANT:
            begin
                done_next  = 1'b1;
                pos_y_next = py_sat;
                state_next = gsa_pkg::ST_IDLE;
                if (py <= PW'(top_limit_reg))
                begin
                    // off the top: cell stays free, grid counts as full
                    full_next    = 1'b1;
                    ok_next      = 1'b0;
                    pos_x_next   = '0;
                    got_col_next = '0;
                    got_row_next = '0;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_addr      = sel_r_reg;
                    wr_data      = word_reg | (MAX_COLS'(1) << sel_c_reg);
                    ok_next      = 1'b1;
                    pos_x_next   = px_sat;
                    got_col_next = 4'(sel_c_reg);
                    got_row_next = 4'(sel_r_reg);
                end
            end

            gsa_pkg::ST_REL:
            begin
                done_next    = 1'b1;
                pos_x_next   = '0;
                pos_y_next   = '0;
                got_col_next = '0;
                got_row_next = '0;
                ok_next      = 1'b0;
                state_next   = gsa_pkg::ST_IDLE;
                if (hint_ok_reg && row_word[col_reg[CW-1:0]])
                begin
                    wr_en   = 1'b1;
                    wr_addr = row_reg[RW-1:0];
                    wr_data = row_word & ~(MAX_COLS'(1) << col_reg[CW-1:0]);
                    ok_next = 1'b1;
                end
            end

            default:
            begin
                state_next = gsa_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsa_pkg::ST_IDLE;
            full_reg      <= 1'b0;
            done_reg      <= 1'b0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
            done_reg  <= done_next;
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= gsa_pkg::RST_GRID_COLS;
            grid_rows_reg <= gsa_pkg::RST_GRID_ROWS;
            origin_x_reg  <= gsa_pkg::RST_ORIGIN_X;
            origin_y_reg  <= gsa_pkg::RST_ORIGIN_Y;
            step_x_reg    <= gsa_pkg::RST_STEP_X;
            step_y_reg    <= gsa_pkg::RST_STEP_Y;
            top_limit_reg <= gsa_pkg::RST_TOP_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                gsa_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_wdata[4:0];
                gsa_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata[4:0];
                gsa_pkg::CFG_ORIGIN_X:  origin_x_reg  <= signed'(cfg_wdata);
                gsa_pkg::CFG_ORIGIN_Y:  origin_y_reg  <= signed'(cfg_wdata);
                gsa_pkg::CFG_STEP_X:    step_x_reg    <= cfg_wdata[11:0];
                gsa_pkg::CFG_STEP_Y:    step_y_reg    <= cfg_wdata[11:0];
                gsa_pkg::CFG_TOP_LIMIT: top_limit_reg <= signed'(cfg_wdata);
                default:
                begin
                end
            endcase
        end
    end

    // request context and result payload
    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        hint_ok_reg <= hint_ok_next;
        chk_r_reg   <= chk_r_next;
        sel_c_reg   <= sel_c_next;
        sel_r_reg   <= sel_r_next;
        word_reg    <= word_next;
        ok_reg      <= ok_next;
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        got_col_reg <= got_col_next;
        got_row_reg <= got_row_next;
    end

    // occupancy memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            occ_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= occ_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/gsa_checker.sv */
// port-level checks for the grid slot allocator, bound to the top level
`default_nettype none

module gsa_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               mode,
    input wire logic               done,
    input wire logic               ok,
    input wire logic signed [15:0] pos_x,
    input wire logic signed [15:0] pos_y,
    input wire logic [3:0]         got_col,
    input wire logic [3:0]         got_row,
    input wire logic               full_res
);

    logic mode_reg;
    logic seen_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            seen_full_reg <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                mode_reg <= mode;
            if (done && full_res)
                seen_full_reg <= 1'b1;
        end
    end

    // a result only shows once the request has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start work");

    // full flag is sticky across results
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (done && seen_full_reg) |-> full_res)
        else $error("full flag dropped");

    // release results carry no position or cell
    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_reg) |-> (pos_x == 16'sd0 && pos_y == 16'sd0
                                && got_col == 4'd0 && got_row == 4'd0))
        else $error("release result with nonzero position");

    // a rejected or failed request sets the full flag
    a_fail_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !mode_reg && !ok) |-> full_res)
        else $error("failed request without full flag");

endmodule

bind grid_slot_allocator_core gsa_checker u_gsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .done     (done),
    .ok       (ok),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .got_col  (got_col),
    .got_row  (got_row),
    .full_res (full_res)
);

`default_nettype wire
